// File: rtl/assert_macros.svh
// assertion macros included by the encoder top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ACE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ACE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ace_pkg.sv
// shared types and constants of the arithmetic encoder
package ace_pkg;

    localparam int NUM_SYMBOLS_DEF = 257;
    localparam int STATE_WIDTH_DEF = 32;

    localparam int FUNC_W  = 2;
    localparam int SYM_W   = 9;
    localparam int IDX_W   = 9;
    localparam int ENTRY_W = 25;
    localparam int COUNT_W = 32;

    // slave tdata layout
    localparam int SYM_LSB   = 0;
    localparam int IDX_LSB   = SYM_LSB + SYM_W;
    localparam int VAL_LSB   = IDX_LSB + IDX_W;
    localparam int S_TDATA_W = ((VAL_LSB + ENTRY_W + 7) / 8) * 8;

    // master tdata layout: lead bit, then follow count
    localparam int M_TDATA_W = ((1 + COUNT_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD   = 2'd0,
        FN_ENCODE = 2'd1,
        FN_FINISH = 2'd2
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_TOTAL,
        ST_RD_LO,
        ST_RD_HI,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_DIVIDE,
        ST_UPDATE,
        ST_RENORM,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic               end_of_stream;
        logic [COUNT_W-1:0] follow_count;
        logic               lead_bit;
    } result_t;

endpackage

// File: rtl/ace_ram.sv
// generic single-port-write, registered-read ram
module ace_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/arithmetic_encoder_unit.sv
// top level of the static-model arithmetic encoder
//
// static-model arithmetic encoder with a STATE_WIDTH-bit low/high state.
// beats on the slave side carry a function in s_tuser: load writes one entry of
// the cumulative frequency table (entry NUM_SYMBOLS is the total), encode narrows
// the interval to the symbol's slice and renormalizes, finish emits the closing
// bit. every lead bit leaves as one master beat with the count of complement
// bits that follow it; m_tlast marks the final beat caused by an input beat and
// m_tuser marks the finish beat. a load or an ignored beat is taken in idle and
// the unit stays there; an encode dropped for a zero total returns to idle from
// RD_LO, and a finish waits in FLUSH through any output stall. an encode steps
// through the read, multiply and divide states, UPDATE, RENORM and FLUSH. the
// bit-serial restoring dividers form both scaled bounds side by side from a
// dividend of PW = STATE_WIDTH + 26 bits (58 at the default width); RENORM makes
// at most STATE_WIDTH shifts, one per cycle unless an output stall holds it, and
// stops once no shift is needed. the table ram has a registered read, so
// the total and the two cumulative entries are fetched in turn. a full master
// register holds the renormalizer only when a second lead bit is ready, since
// one result is kept back to learn whether it is the last. table entries never
// loaded read as undefined data; the total must be loaded before encoding.
`include "assert_macros.svh"

module arithmetic_encoder_unit #(
    parameter int NUM_SYMBOLS = ace_pkg::NUM_SYMBOLS_DEF,
    parameter int STATE_WIDTH = ace_pkg::STATE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    // symbol [8:0], entry_index [17:9], entry_value [42:18], zero fill above
    input  logic [ace_pkg::S_TDATA_W-1:0] s_tdata,
    // func [1:0]
    input  logic [ace_pkg::FUNC_W-1:0]    s_tuser,

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // lead_bit [0], follow_count [32:1], zero fill above
    output logic [ace_pkg::M_TDATA_W-1:0] m_tdata,
    // end_of_stream [0]
    output logic                          m_tuser,
    output logic                          m_tlast
);

    // derived sizes
    localparam int SW      = STATE_WIDTH;
    localparam int EW      = ace_pkg::ENTRY_W;
    localparam int CW      = ace_pkg::COUNT_W;
    localparam int TBL_D   = NUM_SYMBOLS + 1;
    localparam int TBL_AW  = $clog2(TBL_D);
    localparam int RNG_W   = SW + 1;          // range can reach 2^SW
    localparam int PW      = RNG_W + EW;      // product / dividend width
    localparam int DCW     = $clog2(PW);
    localparam int SCW     = $clog2(SW);
    localparam logic [SW-1:0]  QTR_C    = SW'(1) << (SW - 2);
    localparam logic [DCW-1:0] DIV_LAST = DCW'(PW - 1);
    localparam logic [SCW-1:0] SH_LAST  = SCW'(SW - 1);

    // ---------------------------------------------------------------
    // input field unpacking
    // ---------------------------------------------------------------
    ace_pkg::func_t        in_func;
    logic [ace_pkg::SYM_W-1:0] in_symbol;
    logic [ace_pkg::IDX_W-1:0] in_index;
    logic [EW-1:0]         in_value;
    logic                  in_beat;
    logic                  sym_ok;
    logic                  idx_ok;

    assign in_func   = ace_pkg::func_t'(s_tuser);
    assign in_symbol = s_tdata[ace_pkg::SYM_LSB +: ace_pkg::SYM_W];
    assign in_index  = s_tdata[ace_pkg::IDX_LSB +: ace_pkg::IDX_W];
    assign in_value  = s_tdata[ace_pkg::VAL_LSB +: EW];
    assign in_beat   = s_tvalid && s_tready;
    assign sym_ok    = 32'(in_symbol) < NUM_SYMBOLS;
    assign idx_ok    = 32'(in_index) <= NUM_SYMBOLS;

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    ace_pkg::state_t   state_reg, state_next;
    logic [SW-1:0]     low_reg, low_next;
    logic [SW-1:0]     high_reg, high_next;
    logic [CW-1:0]     pending_reg, pending_next;
    logic [TBL_AW-1:0] sym_reg, sym_next;
    logic [EW-1:0]     total_reg, total_next;
    logic [EW-1:0]     slo_reg, slo_next;
    logic [RNG_W-1:0]  range_reg, range_next;
    logic [PW-1:0]     div_reg [2];      // index 0: upper bound, 1: lower bound
    logic [PW-1:0]     div_next [2];
    logic [EW-1:0]     rem_reg [2];
    logic [EW-1:0]     rem_next [2];
    logic [SW-1:0]     quo_reg [2];
    logic [SW-1:0]     quo_next [2];
    logic [DCW-1:0]    div_cnt_reg, div_cnt_next;
    logic [SCW-1:0]    sh_cnt_reg, sh_cnt_next;
    logic              hold_valid_reg, hold_valid_next;
    ace_pkg::result_t  hold_reg, hold_next;
    logic              m_valid_reg, m_valid_next;
    ace_pkg::result_t  m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;

    // ---------------------------------------------------------------
    // cumulative table ram
    // ---------------------------------------------------------------
    logic              tbl_wr_en;
    logic              tbl_rd_en;
    logic [TBL_AW-1:0] tbl_rd_addr;
    logic [EW-1:0]     tbl_rd_data;

    assign tbl_wr_en = in_beat && (in_func == ace_pkg::FN_LOAD) && idx_ok;

    ace_ram #(
        .WIDTH (EW),
        .DEPTH (TBL_D)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (TBL_AW'(in_index)),
        .wr_data (in_value),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    // three reads per encode: total, entry[symbol], entry[symbol + 1]
    always_comb begin
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = TBL_AW'(NUM_SYMBOLS);
        unique case (state_reg)
            ace_pkg::ST_RD_TOTAL: begin
                tbl_rd_en = 1'b1;
            end
            ace_pkg::ST_RD_LO: begin
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = sym_reg;
            end
            ace_pkg::ST_RD_HI: begin
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = sym_reg + TBL_AW'(1);
            end
            default: begin
                tbl_rd_en = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // shared scaler: one multiplier, used for the upper then the lower product
    // ---------------------------------------------------------------
    logic [PW-1:0] mul_b;
    logic [PW-1:0] product;

    assign mul_b   = (state_reg == ace_pkg::ST_MUL_HI) ? PW'(tbl_rd_data) : PW'(slo_reg);
    assign product = PW'(range_reg) * mul_b;

    // ---------------------------------------------------------------
    // two restoring dividers sharing the divisor, one quotient bit a cycle
    // ---------------------------------------------------------------
    logic [EW:0] trial [2];
    logic        q_bit [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            trial[i] = {rem_reg[i], div_reg[i][PW-1]};
            q_bit[i] = trial[i] >= {1'b0, total_reg};
        end
    end

    // ---------------------------------------------------------------
    // renormalization decode
    // ---------------------------------------------------------------
    logic          out_free;
    logic          rn_zero;     // both bounds in the lower half
    logic          rn_one;      // both bounds in the upper half
    logic          rn_mid;      // straddling the middle quarter
    logic          rn_emit;
    logic          rn_stall;
    logic          rn_stop;
    logic [CW-1:0] pending_inc;
    logic          finish_bit;

    assign out_free    = !m_valid_reg || m_tready;
    assign rn_zero     = !high_reg[SW-1];
    assign rn_one      = !rn_zero && low_reg[SW-1];
    assign rn_mid      = (low_reg[SW-1 -: 2] == 2'b01) && (high_reg[SW-1 -: 2] == 2'b10);
    assign rn_emit     = rn_zero || rn_one;
    assign rn_stall    = rn_emit && hold_valid_reg && !out_free;
    assign rn_stop     = !rn_emit && !rn_mid;
    assign pending_inc = (&pending_reg) ? pending_reg : pending_reg + CW'(1);
    assign finish_bit  = low_reg[SW-1 -: 2] != 2'b00;

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ace_pkg::ST_IDLE: begin
                if (in_beat) begin
                    if (in_func == ace_pkg::FN_ENCODE && sym_ok) begin
                        state_next = ace_pkg::ST_RD_TOTAL;
                    end else if (in_func == ace_pkg::FN_FINISH) begin
                        state_next = ace_pkg::ST_FLUSH;
                    end
                end
            end
            ace_pkg::ST_RD_TOTAL: begin
                state_next = ace_pkg::ST_RD_LO;
            end
            ace_pkg::ST_RD_LO: begin
                // a zero total drops the encode
                state_next = (tbl_rd_data == '0) ? ace_pkg::ST_IDLE : ace_pkg::ST_RD_HI;
            end
            ace_pkg::ST_RD_HI: begin
                state_next = ace_pkg::ST_MUL_HI;
            end
            ace_pkg::ST_MUL_HI: begin
                state_next = ace_pkg::ST_MUL_LO;
            end
            ace_pkg::ST_MUL_LO: begin
                state_next = ace_pkg::ST_DIVIDE;
            end
            ace_pkg::ST_DIVIDE: begin
                if (div_cnt_reg == DIV_LAST) begin
                    state_next = ace_pkg::ST_UPDATE;
                end
            end
            ace_pkg::ST_UPDATE: begin
                state_next = ace_pkg::ST_RENORM;
            end
            ace_pkg::ST_RENORM: begin
                if (!rn_stall && (rn_stop || sh_cnt_reg == SH_LAST)) begin
                    state_next = ace_pkg::ST_FLUSH;
                end
            end
            ace_pkg::ST_FLUSH: begin
                if (!hold_valid_reg || out_free) begin
                    state_next = ace_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ace_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // datapath and outputs
    // ---------------------------------------------------------------
    always_comb begin
        low_next        = low_reg;
        high_next       = high_reg;
        pending_next    = pending_reg;
        sym_next        = sym_reg;
        total_next      = total_reg;
        slo_next        = slo_reg;
        range_next      = range_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        div_cnt_next    = div_cnt_reg;
        sh_cnt_next     = sh_cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;

        unique case (state_reg)
            ace_pkg::ST_IDLE: begin
                sym_next = TBL_AW'(in_symbol);
                if (in_beat && in_func == ace_pkg::FN_FINISH) begin
                    // closing bit carries the pending count plus one
                    hold_next.lead_bit      = finish_bit;
                    hold_next.follow_count  = pending_inc;
                    hold_next.end_of_stream = 1'b1;
                    hold_valid_next         = 1'b1;
                    pending_next            = '0;
                end
            end
            ace_pkg::ST_RD_TOTAL: begin
                range_next = {1'b0, SW'(high_reg - low_reg)} + RNG_W'(1);
            end
            ace_pkg::ST_RD_LO: begin
                total_next = tbl_rd_data;
            end
            ace_pkg::ST_RD_HI: begin
                slo_next = tbl_rd_data;
            end
            ace_pkg::ST_MUL_HI: begin
                div_next[0] = product;
            end
            ace_pkg::ST_MUL_LO: begin
                div_next[1]  = product;
                rem_next[0]  = '0;
                rem_next[1]  = '0;
                div_cnt_next = '0;
            end
            ace_pkg::ST_DIVIDE: begin
                for (int i = 0; i < 2; i++) begin
                    rem_next[i] = q_bit[i] ? EW'(trial[i] - {1'b0, total_reg})
                                           : EW'(trial[i]);
                    div_next[i] = div_reg[i] << 1;
                    quo_next[i] = {quo_reg[i][SW-2:0], q_bit[i]};
                end
                div_cnt_next = div_cnt_reg + DCW'(1);
            end
            ace_pkg::ST_UPDATE: begin
                high_next   = low_reg + quo_reg[0] - SW'(1);
                low_next    = low_reg + quo_reg[1];
                sh_cnt_next = '0;
            end
            ace_pkg::ST_RENORM: begin
                if (!rn_stall && !rn_stop) begin
                    if (rn_emit) begin
                        // earlier result is known not to be the last one
                        if (hold_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_data_next  = hold_reg;
                            m_last_next  = 1'b0;
                        end
                        hold_next.lead_bit      = rn_one;
                        hold_next.follow_count  = pending_reg;
                        hold_next.end_of_stream = 1'b0;
                        hold_valid_next         = 1'b1;
                        pending_next            = '0;
                        if (rn_one) begin
                            low_next  = {1'b0, low_reg[SW-2:0]} << 1;
                            high_next = ({1'b0, high_reg[SW-2:0]} << 1) | SW'(1);
                        end else begin
                            low_next  = low_reg << 1;
                            high_next = (high_reg << 1) | SW'(1);
                        end
                    end else begin
                        pending_next = pending_inc;
                        low_next     = SW'(low_reg - QTR_C) << 1;
                        high_next    = (SW'(high_reg - QTR_C) << 1) | SW'(1);
                    end
                    sh_cnt_next = sh_cnt_reg + SCW'(1);
                end
            end
            ace_pkg::ST_FLUSH: begin
                if (hold_valid_reg && out_free) begin
                    m_valid_next    = 1'b1;
                    m_data_next     = hold_reg;
                    m_last_next     = 1'b1;
                    hold_valid_next = 1'b0;
                end
            end
            default: begin
                hold_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ace_pkg::ST_IDLE;
            low_reg        <= '0;
            high_reg       <= '1;
            pending_reg    <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            pending_reg    <= pending_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg     <= sym_next;
        total_reg   <= total_next;
        slo_reg     <= slo_next;
        range_reg   <= range_next;
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        div_cnt_reg <= div_cnt_next;
        sh_cnt_reg  <= sh_cnt_next;
        hold_reg    <= hold_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
    end

    // ---------------------------------------------------------------
    // ports
    // ---------------------------------------------------------------
    assign s_tready = (state_reg == ace_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = ace_pkg::M_TDATA_W'({m_data_reg.follow_count, m_data_reg.lead_bit});
    assign m_tuser  = m_data_reg.end_of_stream;
    assign m_tlast  = m_last_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `ACE_ASSERT_IMP(a_idle_no_hold, aclk, aresetn, (state_reg == ace_pkg::ST_IDLE), (!hold_valid_reg), "held result left behind at idle")
    `ACE_ASSERT_NXT(a_emit_clears_pending, aclk, aresetn, (state_reg == ace_pkg::ST_RENORM && rn_emit && !rn_stall), (pending_reg == '0), "pending count not cleared after emit")
    `ACE_ASSERT_IMP(a_eos_is_last, aclk, aresetn, (m_valid_reg && m_data_reg.end_of_stream), (m_last_reg), "end of stream beat without last")
    `ACE_ASSERT_IMP(a_rem_below_total, aclk, aresetn, (state_reg == ace_pkg::ST_DIVIDE), (rem_reg[0] < total_reg && rem_reg[1] < total_reg), "divider remainder out of range")

endmodule
